### rtl/sse_pkg.sv
// Shared types, constants and the round/saturate helper for the shell strain
// energy block. No dependencies; every other file imports this package.
`default_nettype none

package sse_pkg;

    localparam int IN_W       = 16;
    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 8;
    localparam int OUT_W      = 48;
    localparam int ROW_W      = 3;
    localparam int N_IN       = 6;
    localparam int N_OUT_DATA = 8;
    localparam int S_TDATA_W  = IN_W * N_IN;
    localparam int M_TDATA_W  = OUT_W * N_OUT_DATA;
    localparam int WIDE_W     = 104;

    localparam int ONE_Q12 = 4096;
    localparam int TWO_Q12 = 8192;

    localparam int GRAD_S_FRAC = 12;
    localparam int GRAD_B_FRAC = 36;
    localparam int HESS_B_FRAC = 24;
    localparam int ENERGY_FRAC = 48;

    localparam logic [CFG_ADDR_W-1:0] REG_STRETCH_SUM = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_STRETCH     = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_BEND_SUM    = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_BEND_DET    = CFG_ADDR_W'(3);

    localparam logic [ROW_W-1:0] ROW_STRETCH_U  = ROW_W'(0);
    localparam logic [ROW_W-1:0] ROW_SHEAR      = ROW_W'(1);
    localparam logic [ROW_W-1:0] ROW_STRETCH_V  = ROW_W'(2);
    localparam logic [ROW_W-1:0] ROW_BEND_U     = ROW_W'(3);
    localparam logic [ROW_W-1:0] ROW_BEND_TWIST = ROW_W'(4);
    localparam logic [ROW_W-1:0] ROW_BEND_V     = ROW_W'(5);
    localparam logic [ROW_W-1:0] ROW_LAST       = ROW_BEND_V;

    typedef struct packed {
        logic signed [CFG_W-1:0] a0;
        logic signed [CFG_W-1:0] a1;
        logic signed [CFG_W-1:0] b0;
        logic signed [CFG_W-1:0] b1;
    } coeff_t;

    typedef struct packed {
        logic signed [IN_W-1:0] stretch_u;
        logic signed [IN_W-1:0] shear;
        logic signed [IN_W-1:0] stretch_v;
        logic signed [IN_W-1:0] bend_u;
        logic signed [IN_W-1:0] bend_twist;
        logic signed [IN_W-1:0] bend_v;
    } strain_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] energy;
        logic [N_IN-1:0][OUT_W-1:0] grad;
        logic signed [OUT_W-1:0] h33;
        logic signed [OUT_W-1:0] h34;
        logic signed [OUT_W-1:0] h35;
        logic signed [OUT_W-1:0] h44;
        logic signed [OUT_W-1:0] h45;
        logic signed [OUT_W-1:0] h55;
    } result_t;

    // round to nearest (ties up) after dropping n fraction bits, then clamp
    function automatic logic signed [OUT_W-1:0] round_sat(
        input logic signed [WIDE_W-1:0] v,
        input int unsigned n
    );
        logic signed [WIDE_W-1:0] t;
        logic [WIDE_W-OUT_W:0] hi_bits;
        t = v;
        if (n != 0) begin
            t = t + (WIDE_W'(1) <<< (n - 1));
        end
        t = t >>> n;
        hi_bits = t[WIDE_W-1:OUT_W-1];
        if ((&hi_bits) || !(|hi_bits)) begin
            round_sat = t[OUT_W-1:0];
        end else if (t[WIDE_W-1]) begin
            round_sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            round_sat = {1'b0, {(OUT_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

### rtl/sse_cfg.sv
// Stiffness coefficient registers, written through the plain write port.
// Depends on sse_pkg.
`default_nettype none

module sse_cfg
    import sse_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    output coeff_t                     coeff
);

    coeff_t coeff_reg;
    coeff_t coeff_next;

    always_comb begin
        coeff_next = coeff_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_STRETCH_SUM: coeff_next.a0 = cfg_wdata;
                REG_STRETCH:     coeff_next.a1 = cfg_wdata;
                REG_BEND_SUM:    coeff_next.b0 = cfg_wdata;
                REG_BEND_DET:    coeff_next.b1 = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg <= '0;
        end else begin
            coeff_reg <= coeff_next;
        end
    end

    assign coeff = coeff_reg;

endmodule

`default_nettype wire

### rtl/sse_pipe.sv
// Seven-stage datapath: energy, gradient and bend Hessian of one strain word.
// Depends on sse_pkg; coefficients come from sse_cfg.
`default_nettype none

module sse_pipe
    import sse_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  coeff_t    coeff,
    input  wire logic in_valid,
    output logic      in_ready,
    input  strain_t   in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   out_result
);

    localparam int NSTAGE = 7;

    typedef struct packed {
        logic signed [17:0] ssum;
        logic signed [16:0] du;
        logic signed [16:0] dv;
        logic signed [16:0] ksum;
        logic signed [15:0] s1;
        logic signed [15:0] k0;
        logic signed [15:0] k1;
        logic signed [15:0] k2;
        logic signed [31:0] p02;
        logic signed [31:0] p11;
        logic signed [31:0] p22;
        logic signed [31:0] p00;
        logic signed [31:0] p12;
        logic signed [31:0] p01;
    } st1_t;

    typedef struct packed {
        logic signed [32:0] det;
        logic signed [33:0] hx33;
        logic signed [33:0] hx34;
        logic signed [33:0] hx35;
        logic signed [33:0] hx44;
        logic signed [33:0] hx45;
        logic signed [33:0] hx55;
        logic signed [33:0] ksq;
        logic signed [35:0] ssq;
        logic signed [33:0] dusq;
        logic signed [33:0] dvsq;
        logic signed [31:0] s1sq;
        logic signed [48:0] a1du;
        logic signed [49:0] a0ss;
        logic signed [48:0] a1dv;
        logic signed [47:0] a1s1;
        logic signed [48:0] b0ks;
        logic signed [15:0] k0;
        logic signed [15:0] k1;
        logic signed [15:0] k2;
    } st2_t;

    typedef struct packed {
        logic signed [34:0] squad;
        logic signed [63:0] bdet;
        logic signed [65:0] hp33;
        logic signed [65:0] hp34;
        logic signed [65:0] hp35;
        logic signed [65:0] hp44;
        logic signed [65:0] hp45;
        logic signed [65:0] hp55;
        logic signed [51:0] gs0;
        logic signed [49:0] gs1;
        logic signed [51:0] gs2;
        logic signed [33:0] ksq;
        logic signed [35:0] ssq;
        logic signed [48:0] b0ks;
        logic signed [32:0] det;
        logic signed [15:0] k0;
        logic signed [15:0] k1;
        logic signed [15:0] k2;
    } st3_t;

    typedef struct packed {
        logic signed [67:0] eb;
        logic signed [67:0] ea0;
        logic signed [67:0] ea1;
        logic signed [65:0] bdl;
        logic signed [65:0] bdh;
        logic signed [79:0] bk0;
        logic signed [79:0] bk1;
        logic signed [79:0] bk2;
        logic signed [67:0] h33w;
        logic signed [67:0] h34w;
        logic signed [67:0] h35w;
        logic signed [67:0] h44w;
        logic signed [67:0] h45w;
        logic signed [67:0] h55w;
        logic signed [OUT_W-1:0] g0;
        logic signed [OUT_W-1:0] g1;
        logic signed [OUT_W-1:0] g2;
        logic signed [48:0] b0ks;
    } st4_t;

    typedef struct packed {
        logic signed [69:0] equad;
        logic signed [99:0] ebend;
        logic signed [81:0] g3w;
        logic signed [81:0] g4w;
        logic signed [81:0] g5w;
        logic signed [OUT_W-1:0] h33;
        logic signed [OUT_W-1:0] h34;
        logic signed [OUT_W-1:0] h35;
        logic signed [OUT_W-1:0] h44;
        logic signed [OUT_W-1:0] h45;
        logic signed [OUT_W-1:0] h55;
        logic signed [OUT_W-1:0] g0;
        logic signed [OUT_W-1:0] g1;
        logic signed [OUT_W-1:0] g2;
    } st5_t;

    typedef struct packed {
        logic signed [99:0] ew;
        logic [N_IN-1:0][OUT_W-1:0] grad;
        logic signed [OUT_W-1:0] h33;
        logic signed [OUT_W-1:0] h34;
        logic signed [OUT_W-1:0] h35;
        logic signed [OUT_W-1:0] h44;
        logic signed [OUT_W-1:0] h45;
        logic signed [OUT_W-1:0] h55;
    } st6_t;

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [NSTAGE-1:0] adv;

    st1_t    st1_reg, st1_next;
    st2_t    st2_reg, st2_next;
    st3_t    st3_reg, st3_next;
    st4_t    st4_reg, st4_next;
    st5_t    st5_reg, st5_next;
    st6_t    st6_reg, st6_next;
    result_t res_reg, res_next;

    // a stage loads when it is empty or its contents move on
    always_comb begin
        adv[NSTAGE-1] = !vld_reg[NSTAGE-1] || out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign vld_next = (vld_reg & ~adv) | ({vld_reg[NSTAGE-2:0], in_valid} & adv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: offsets and bend products
    always_comb begin
        st1_next.ssum = 18'(in_data.stretch_u) + 18'(in_data.stretch_v) - 18'(TWO_Q12);
        st1_next.du   = 17'(in_data.stretch_u) - 17'(ONE_Q12);
        st1_next.dv   = 17'(in_data.stretch_v) - 17'(ONE_Q12);
        st1_next.ksum = 17'(in_data.bend_u) + 17'(in_data.bend_v);
        st1_next.s1   = in_data.shear;
        st1_next.k0   = in_data.bend_u;
        st1_next.k1   = in_data.bend_twist;
        st1_next.k2   = in_data.bend_v;
        st1_next.p02  = 32'(in_data.bend_u) * 32'(in_data.bend_v);
        st1_next.p11  = 32'(in_data.bend_twist) * 32'(in_data.bend_twist);
        st1_next.p22  = 32'(in_data.bend_v) * 32'(in_data.bend_v);
        st1_next.p00  = 32'(in_data.bend_u) * 32'(in_data.bend_u);
        st1_next.p12  = 32'(in_data.bend_twist) * 32'(in_data.bend_v);
        st1_next.p01  = 32'(in_data.bend_u) * 32'(in_data.bend_twist);
    end

    // stage 2: squares, gradient products, bend combinations
    always_comb begin
        st2_next.det  = 33'(st1_reg.p02) - 33'(st1_reg.p11);
        st2_next.hx33 = 34'(st1_reg.p22);
        st2_next.hx34 = -34'(st1_reg.p12);
        st2_next.hx35 = (34'(st1_reg.p02) <<< 1) - 34'(st1_reg.p11);
        st2_next.hx44 = (34'(st1_reg.p11) <<< 1) + 34'(st1_reg.p11) - 34'(st1_reg.p02);
        st2_next.hx45 = -34'(st1_reg.p01);
        st2_next.hx55 = 34'(st1_reg.p00);
        st2_next.ksq  = 34'(st1_reg.ksum) * 34'(st1_reg.ksum);
        st2_next.ssq  = 36'(st1_reg.ssum) * 36'(st1_reg.ssum);
        st2_next.dusq = 34'(st1_reg.du) * 34'(st1_reg.du);
        st2_next.dvsq = 34'(st1_reg.dv) * 34'(st1_reg.dv);
        st2_next.s1sq = 32'(st1_reg.s1) * 32'(st1_reg.s1);
        st2_next.a1du = 49'(coeff.a1) * 49'(st1_reg.du);
        st2_next.a0ss = 50'(coeff.a0) * 50'(st1_reg.ssum);
        st2_next.a1dv = 49'(coeff.a1) * 49'(st1_reg.dv);
        st2_next.a1s1 = 48'(coeff.a1) * 48'(st1_reg.s1);
        st2_next.b0ks = 49'(coeff.b0) * 49'(st1_reg.ksum);
        st2_next.k0   = st1_reg.k0;
        st2_next.k1   = st1_reg.k1;
        st2_next.k2   = st1_reg.k2;
    end

    // stage 3: determinant and bend Hessian products, stretch gradient sums
    always_comb begin
        st3_next.squad = 35'(st2_reg.dusq) + 35'(st2_reg.dvsq) + (35'(st2_reg.s1sq) <<< 1);
        st3_next.bdet  = 64'(coeff.b1) * 64'(st2_reg.det);
        st3_next.hp33  = 66'(coeff.b1) * 66'(st2_reg.hx33);
        st3_next.hp34  = 66'(coeff.b1) * 66'(st2_reg.hx34);
        st3_next.hp35  = 66'(coeff.b1) * 66'(st2_reg.hx35);
        st3_next.hp44  = 66'(coeff.b1) * 66'(st2_reg.hx44);
        st3_next.hp45  = 66'(coeff.b1) * 66'(st2_reg.hx45);
        st3_next.hp55  = 66'(coeff.b1) * 66'(st2_reg.hx55);
        st3_next.gs0   = (52'(st2_reg.a1du) + 52'(st2_reg.a0ss)) <<< 1;
        st3_next.gs1   = 50'(st2_reg.a1s1) <<< 2;
        st3_next.gs2   = (52'(st2_reg.a1dv) + 52'(st2_reg.a0ss)) <<< 1;
        st3_next.ksq   = st2_reg.ksq;
        st3_next.ssq   = st2_reg.ssq;
        st3_next.b0ks  = st2_reg.b0ks;
        st3_next.det   = st2_reg.det;
        st3_next.k0    = st2_reg.k0;
        st3_next.k1    = st2_reg.k1;
        st3_next.k2    = st2_reg.k2;
    end

    // stage 4: energy and bend gradient products, split determinant square, Hessian sums, stretch gradient rounding
    always_comb begin
        logic signed [67:0] bsh;
        bsh = 68'(coeff.b0) <<< 24;
        st4_next.eb   = 68'(coeff.b0) * 68'(st3_reg.ksq);
        st4_next.ea0  = 68'(coeff.a0) * 68'(st3_reg.ssq);
        st4_next.ea1  = 68'(coeff.a1) * 68'(st3_reg.squad);
        st4_next.bdl  = 66'($signed({1'b0, st3_reg.bdet[31:0]})) * 66'(st3_reg.det);
        st4_next.bdh  = 66'($signed(st3_reg.bdet[63:32])) * 66'(st3_reg.det);
        st4_next.bk0  = 80'(st3_reg.bdet) * 80'(st3_reg.k0);
        st4_next.bk1  = 80'(st3_reg.bdet) * 80'(st3_reg.k1);
        st4_next.bk2  = 80'(st3_reg.bdet) * 80'(st3_reg.k2);
        st4_next.h33w = (bsh + 68'(st3_reg.hp33)) <<< 1;
        st4_next.h34w = 68'(st3_reg.hp34) <<< 2;
        st4_next.h35w = (bsh + 68'(st3_reg.hp35)) <<< 1;
        st4_next.h44w = 68'(st3_reg.hp44) <<< 2;
        st4_next.h45w = 68'(st3_reg.hp45) <<< 2;
        st4_next.h55w = (bsh + 68'(st3_reg.hp55)) <<< 1;
        st4_next.g0   = round_sat(WIDE_W'(st3_reg.gs0), GRAD_S_FRAC);
        st4_next.g1   = round_sat(WIDE_W'(st3_reg.gs1), GRAD_S_FRAC);
        st4_next.g2   = round_sat(WIDE_W'(st3_reg.gs2), GRAD_S_FRAC);
        st4_next.b0ks = st3_reg.b0ks;
    end

    // stage 5: energy partial sums, bend gradient sums, bend Hessian rounding
    always_comb begin
        st5_next.equad = 70'(st4_reg.eb) + 70'(st4_reg.ea0) + 70'(st4_reg.ea1);
        st5_next.ebend = (100'(st4_reg.bdh) <<< 32) + 100'(st4_reg.bdl);
        st5_next.g3w   = (82'(st4_reg.b0ks) <<< 25) + (82'(st4_reg.bk2) <<< 1);
        st5_next.g4w   = -(82'(st4_reg.bk1) <<< 2);
        st5_next.g5w   = (82'(st4_reg.b0ks) <<< 25) + (82'(st4_reg.bk0) <<< 1);
        st5_next.h33   = round_sat(WIDE_W'(st4_reg.h33w), HESS_B_FRAC);
        st5_next.h34   = round_sat(WIDE_W'(st4_reg.h34w), HESS_B_FRAC);
        st5_next.h35   = round_sat(WIDE_W'(st4_reg.h35w), HESS_B_FRAC);
        st5_next.h44   = round_sat(WIDE_W'(st4_reg.h44w), HESS_B_FRAC);
        st5_next.h45   = round_sat(WIDE_W'(st4_reg.h45w), HESS_B_FRAC);
        st5_next.h55   = round_sat(WIDE_W'(st4_reg.h55w), HESS_B_FRAC);
        st5_next.g0    = st4_reg.g0;
        st5_next.g1    = st4_reg.g1;
        st5_next.g2    = st4_reg.g2;
    end

    // stage 6: full energy sum, bend gradient rounding
    always_comb begin
        st6_next.ew      = (100'(st5_reg.equad) <<< 24) + st5_reg.ebend;
        st6_next.grad[0] = st5_reg.g0;
        st6_next.grad[1] = st5_reg.g1;
        st6_next.grad[2] = st5_reg.g2;
        st6_next.grad[3] = round_sat(WIDE_W'(st5_reg.g3w), GRAD_B_FRAC);
        st6_next.grad[4] = round_sat(WIDE_W'(st5_reg.g4w), GRAD_B_FRAC);
        st6_next.grad[5] = round_sat(WIDE_W'(st5_reg.g5w), GRAD_B_FRAC);
        st6_next.h33     = st5_reg.h33;
        st6_next.h34     = st5_reg.h34;
        st6_next.h35     = st5_reg.h35;
        st6_next.h44     = st5_reg.h44;
        st6_next.h45     = st5_reg.h45;
        st6_next.h55     = st5_reg.h55;
    end

    // stage 7: energy rounding
    always_comb begin
        res_next.energy = round_sat(WIDE_W'(st6_reg.ew), ENERGY_FRAC);
        res_next.grad   = st6_reg.grad;
        res_next.h33    = st6_reg.h33;
        res_next.h34    = st6_reg.h34;
        res_next.h35    = st6_reg.h35;
        res_next.h44    = st6_reg.h44;
        res_next.h45    = st6_reg.h45;
        res_next.h55    = st6_reg.h55;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            st1_reg <= st1_next;
        end
        if (adv[1]) begin
            st2_reg <= st2_next;
        end
        if (adv[2]) begin
            st3_reg <= st3_next;
        end
        if (adv[3]) begin
            st4_reg <= st4_next;
        end
        if (adv[4]) begin
            st5_reg <= st5_next;
        end
        if (adv[5]) begin
            st6_reg <= st6_next;
        end
        if (adv[6]) begin
            res_reg <= res_next;
        end
    end

    assign in_ready   = adv[0];
    assign out_valid  = vld_reg[NSTAGE-1];
    assign out_result = res_reg;

endmodule

`default_nettype wire

### rtl/sse_rows.sv
// Row sequencer: holds one finished result and sends it as six row words,
// adding the constant stretch Hessian entries. Depends on sse_pkg.
`default_nettype none

module sse_rows
    import sse_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  coeff_t                    coeff,
    input  wire logic                 res_valid,
    output logic                      res_ready,
    input  result_t                   res,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [ROW_W-1:0]          m_tuser,
    output logic                      m_tlast
);

    logic             full_reg, full_next;
    logic [ROW_W-1:0] row_reg, row_next;
    result_t          hold_reg;

    logic signed [OUT_W-1:0]    h00;
    logic signed [OUT_W-1:0]    h02;
    logic signed [OUT_W-1:0]    h11;
    logic [OUT_W-1:0]           grad_sel;
    logic [N_IN-1:0][OUT_W-1:0] hrow;
    logic                       load;

    assign res_ready = !full_reg || (m_tready && (row_reg == ROW_LAST));
    assign load      = res_valid && res_ready;

    always_comb begin
        full_next = full_reg;
        row_next  = row_reg;
        if (full_reg && m_tready) begin
            if (row_reg == ROW_LAST) begin
                full_next = 1'b0;
            end else begin
                row_next = row_reg + ROW_W'(1);
            end
        end
        if (load) begin
            full_next = 1'b1;
            row_next  = ROW_STRETCH_U;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            row_reg  <= ROW_STRETCH_U;
        end else begin
            full_reg <= full_next;
            row_reg  <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hold_reg <= res;
        end
    end

    // stretch block depends on the coefficients only
    assign h00 = (OUT_W'(coeff.a0) + OUT_W'(coeff.a1)) <<< 1;
    assign h02 = OUT_W'(coeff.a0) <<< 1;
    assign h11 = OUT_W'(coeff.a1) <<< 2;

    always_comb begin
        hrow     = '0;
        grad_sel = '0;
        case (row_reg)
            ROW_STRETCH_U: begin
                grad_sel = hold_reg.grad[0];
                hrow[0]  = h00;
                hrow[2]  = h02;
            end
            ROW_SHEAR: begin
                grad_sel = hold_reg.grad[1];
                hrow[1]  = h11;
            end
            ROW_STRETCH_V: begin
                grad_sel = hold_reg.grad[2];
                hrow[0]  = h02;
                hrow[2]  = h00;
            end
            ROW_BEND_U: begin
                grad_sel = hold_reg.grad[3];
                hrow[3]  = hold_reg.h33;
                hrow[4]  = hold_reg.h34;
                hrow[5]  = hold_reg.h35;
            end
            ROW_BEND_TWIST: begin
                grad_sel = hold_reg.grad[4];
                hrow[3]  = hold_reg.h34;
                hrow[4]  = hold_reg.h44;
                hrow[5]  = hold_reg.h45;
            end
            ROW_BEND_V: begin
                grad_sel = hold_reg.grad[5];
                hrow[3]  = hold_reg.h35;
                hrow[4]  = hold_reg.h45;
                hrow[5]  = hold_reg.h55;
            end
            default: ;
        endcase
    end

    assign m_tvalid = full_reg;
    assign m_tdata  = {hrow, grad_sel, hold_reg.energy};
    assign m_tuser  = row_reg;
    assign m_tlast  = (row_reg == ROW_LAST);

endmodule

`default_nettype wire

### rtl/shell_strain_energy_derivatives_top.sv
// Shell strain energy with gradient and Hessian: top level.
// Depends on sse_pkg, sse_cfg, sse_pipe and sse_rows.
//
// Usage: a strain word (six signed Q3.12 values) enters on the s_ channel;
// for each one, six row words leave on the m_ channel, row 0 first. Each row
// carries the energy, one gradient entry and one Hessian row, all signed
// Q31.16 rounded and saturated to 48 bits; m_tuser gives the row number and
// m_tlast marks row 5. The four stiffness coefficients (signed Q15.16) are
// written through cfg_wr_en/cfg_addr/cfg_wdata while no word is in flight;
// addresses past 3 are ignored.
// Row 0 becomes valid once its strain word, loaded into stage 1 by the edge
// that takes it, has passed six more stages and the row holding register.
// The sustained strain word rate is set by the six row words per input on the
// single result channel; the seven-stage datapath takes a word every cycle
// until it fills, so bursts of up to 8 are absorbed. Reset (aresetn low,
// synchronous) clears the coefficients to zero and empties the pipeline. When
// m_tready is low the current row holds and the datapath keeps filling its
// empty stages, then s_tready drops; nothing is lost or repeated.
`default_nettype none

module shell_strain_energy_derivatives_top
    import sse_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // stretch_u, shear, stretch_v, bend_u, bend_twist, bend_v
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // energy, gradient_entry, hess_col0 .. hess_col5
    output logic [M_TDATA_W-1:0]       m_tdata,
    // row_index
    output logic [ROW_W-1:0]           m_tuser,
    output logic                       m_tlast
);

    coeff_t  coeff;
    strain_t strain;
    result_t res;
    logic    res_valid;
    logic    res_ready;

    assign strain.stretch_u  = s_tdata[0*IN_W +: IN_W];
    assign strain.shear      = s_tdata[1*IN_W +: IN_W];
    assign strain.stretch_v  = s_tdata[2*IN_W +: IN_W];
    assign strain.bend_u     = s_tdata[3*IN_W +: IN_W];
    assign strain.bend_twist = s_tdata[4*IN_W +: IN_W];
    assign strain.bend_v     = s_tdata[5*IN_W +: IN_W];

    sse_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .coeff     (coeff)
    );

    sse_pipe u_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .coeff      (coeff),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (strain),
        .out_valid  (res_valid),
        .out_ready  (res_ready),
        .out_result (res)
    );

    sse_rows u_rows (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .coeff     (coeff),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

### verif/shell_strain_energy_derivatives_top_tb.sv
// Self-checking testbench for shell_strain_energy_derivatives_top: strain words in, six row
// words out, each row checked field by field against a fixed-point energy/gradient/Hessian
// predictor kept in this file. Depends on sse_pkg and the RTL only.
`default_nettype none

module shell_strain_energy_derivatives_top_tb
    import sse_pkg::*;
();

    typedef logic signed [127:0] acc_t;

    typedef struct packed {
        logic [ROW_W-1:0]           row;
        logic [OUT_W-1:0]           energy;
        logic [OUT_W-1:0]           grad;
        logic [5:0][OUT_W-1:0]      hess;
        logic                       last;
    } row_word_t;

    localparam acc_t OUT_MAX = (acc_t'(1) <<< (OUT_W - 1)) - 1;
    localparam acc_t OUT_MIN = -(acc_t'(1) <<< (OUT_W - 1));

    localparam logic [CFG_ADDR_W-1:0] REG_BEYOND_LAST = REG_BEND_DET + CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_ADDR_TOP    = '1;

    localparam logic [IN_W-1:0] S_MAX  = 16'h7FFF;
    localparam logic [IN_W-1:0] S_MIN  = 16'h8000;
    localparam logic [IN_W-1:0] S_ONE  = 16'h1000;
    localparam logic [IN_W-1:0] S_ZERO = 16'h0000;
    localparam logic [CFG_W-1:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [CFG_W-1:0] C_MIN = 32'h8000_0000;

    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 41;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [ROW_W-1:0]      m_tuser;
    logic                  m_tlast;

    coeff_t    stiff = '0;
    row_word_t rows_due[$];
    int        fail_count = 0;
    bit        steady = 1'b0;

    shell_strain_energy_derivatives_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("[shell_strain_energy_derivatives_top] ERROR");
        $finish;
    end

    // round to nearest with ties up, then clamp to 48 bits
    function automatic logic [OUT_W-1:0] round_to_out(acc_t v, int unsigned frac);
        acc_t t;
        t = v;
        if (frac != 0) begin
            t = t + (acc_t'(1) <<< (frac - 1));
        end
        t = t >>> frac;
        if (t > OUT_MAX) return OUT_MAX[OUT_W-1:0];
        if (t < OUT_MIN) return OUT_MIN[OUT_W-1:0];
        return t[OUT_W-1:0];
    endfunction

    function automatic void predict_rows(strain_t s);
        acc_t a0, a1, b0, b1, s0, s1, s2, k0, k1, k2;
        acc_t ssum, du, dv, ksum, det, bdet, e, bsum, bs;
        logic [OUT_W-1:0] energy;
        logic [OUT_W-1:0] grad [6];
        logic [OUT_W-1:0] hm [6][6];
        row_word_t w;
        a0 = stiff.a0;
        a1 = stiff.a1;
        b0 = stiff.b0;
        b1 = stiff.b1;
        s0 = s.stretch_u;
        s1 = s.shear;
        s2 = s.stretch_v;
        k0 = s.bend_u;
        k1 = s.bend_twist;
        k2 = s.bend_v;
        ssum = s0 + s2 - TWO_Q12;
        du   = s0 - ONE_Q12;
        dv   = s2 - ONE_Q12;
        ksum = k0 + k2;
        det  = k0 * k2 - k1 * k1;
        bdet = b1 * det;

        // stretch and bend-sum terms at q.40, lifted to q.64 before the determinant term
        e = b0 * ksum * ksum + a0 * ssum * ssum + a1 * (du * du + dv * dv + 2 * s1 * s1);
        e = (e <<< 24) + bdet * det;
        energy = round_to_out(e, ENERGY_FRAC);

        grad[0] = round_to_out(2 * a1 * du + 2 * a0 * ssum, GRAD_S_FRAC);
        grad[1] = round_to_out(4 * a1 * s1, GRAD_S_FRAC);
        grad[2] = round_to_out(2 * a1 * dv + 2 * a0 * ssum, GRAD_S_FRAC);
        bsum = (2 * b0 * ksum) <<< 24;
        grad[3] = round_to_out(bsum + 2 * bdet * k2, GRAD_B_FRAC);
        grad[4] = round_to_out(-4 * bdet * k1, GRAD_B_FRAC);
        grad[5] = round_to_out(bsum + 2 * bdet * k0, GRAD_B_FRAC);

        foreach (hm[r, c]) hm[r][c] = '0;
        hm[0][0] = round_to_out(2 * (a0 + a1), 0);
        hm[0][2] = round_to_out(2 * a0, 0);
        hm[2][0] = hm[0][2];
        hm[2][2] = hm[0][0];
        hm[1][1] = round_to_out(4 * a1, 0);
        bs = b0 <<< 24;
        hm[3][3] = round_to_out(2 * (bs + b1 * k2 * k2), HESS_B_FRAC);
        hm[3][4] = round_to_out(-4 * b1 * k1 * k2, HESS_B_FRAC);
        hm[4][3] = hm[3][4];
        hm[3][5] = round_to_out(2 * (bs + b1 * (2 * k0 * k2 - k1 * k1)), HESS_B_FRAC);
        hm[5][3] = hm[3][5];
        hm[4][4] = round_to_out(4 * b1 * (3 * k1 * k1 - k0 * k2), HESS_B_FRAC);
        hm[4][5] = round_to_out(-4 * b1 * k0 * k1, HESS_B_FRAC);
        hm[5][4] = hm[4][5];
        hm[5][5] = round_to_out(2 * (bs + b1 * k0 * k0), HESS_B_FRAC);

        for (int r = 0; r < 6; r++) begin
            w.row    = ROW_W'(r);
            w.energy = energy;
            w.grad   = grad[r];
            for (int c = 0; c < 6; c++) w.hess[c] = hm[r][c];
            w.last   = (w.row == ROW_LAST);
            rows_due.push_back(w);
        end
    endfunction

    function automatic strain_t make_strain(logic [IN_W-1:0] su, logic [IN_W-1:0] sh,
                                            logic [IN_W-1:0] sv, logic [IN_W-1:0] bu,
                                            logic [IN_W-1:0] bt, logic [IN_W-1:0] bv);
        strain_t s;
        s.stretch_u  = su;
        s.shear      = sh;
        s.stretch_v  = sv;
        s.bend_u     = bu;
        s.bend_twist = bt;
        s.bend_v     = bv;
        return s;
    endfunction

    function automatic strain_t random_strain(bit near_rest);
        if (near_rest) begin
            return make_strain(16'(3584 + $urandom_range(0, 1024)),
                               16'($urandom_range(0, 1024) - 512),
                               16'(3584 + $urandom_range(0, 1024)),
                               16'($urandom_range(0, 8192) - 4096),
                               16'($urandom_range(0, 8192) - 4096),
                               16'($urandom_range(0, 8192) - 4096));
        end
        return make_strain(16'($urandom()), 16'($urandom()), 16'($urandom()),
                           16'($urandom()), 16'($urandom()), 16'($urandom()));
    endfunction

    function automatic logic [CFG_W-1:0] pick_coeff();
        case ($urandom_range(0, 4))
            0, 1: return 32'($urandom());
            2, 3: return 32'($urandom_range(0, 524288) - 262144);
            default: begin
                case ($urandom_range(0, 2))
                    0: return C_MAX;
                    1: return C_MIN;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    task automatic send_strain(strain_t s);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {s.bend_v, s.bend_twist, s.bend_u, s.stretch_v, s.shear, s.stretch_u};
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        predict_rows(s);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (rows_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_STRETCH_SUM: stiff.a0 = val;
            REG_STRETCH:     stiff.a1 = val;
            REG_BEND_SUM:    stiff.b0 = val;
            REG_BEND_DET:    stiff.b1 = val;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_coeffs(logic [CFG_W-1:0] a0, logic [CFG_W-1:0] a1,
                              logic [CFG_W-1:0] b0, logic [CFG_W-1:0] b1);
        wait_drained();
        write_reg(REG_STRETCH_SUM, a0);
        write_reg(REG_STRETCH, a1);
        write_reg(REG_BEND_SUM, b0);
        write_reg(REG_BEND_DET, b1);
    endtask

    task automatic compare_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch %s: expected %h got %h", name, want, got);
        end
    endtask

    // coefficients straight out of reset are zero, so every output must be zero
    task automatic check_reset_coefficients();
        send_strain(make_strain(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN));
        send_strain(make_strain(S_ONE, S_ZERO, S_ONE, S_ZERO, S_ZERO, S_ZERO));
    endtask

    task automatic check_directed_strains();
        set_coeffs(32'sh0001_0000, 32'sh0000_8000, -32'sd147456, 32'sd196608);
        send_strain(make_strain(S_ONE, S_ZERO, S_ONE, S_ZERO, S_ZERO, S_ZERO));
        send_strain(make_strain(S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO));
        send_strain(make_strain(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
        send_strain(make_strain(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
        send_strain(make_strain(S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN));
        send_strain(make_strain(S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX));
        send_strain(make_strain(S_ONE, S_MAX, S_ONE, S_ZERO, S_ZERO, S_ZERO));
        send_strain(make_strain(S_ONE, S_MIN, S_ONE, S_ZERO, S_ZERO, S_ZERO));
        // pure twist gives a negative determinant
        send_strain(make_strain(S_ONE, S_ZERO, S_ONE, S_ZERO, S_MAX, S_ZERO));
        send_strain(make_strain(S_ZERO, S_ZERO, S_ZERO, S_MAX, S_ZERO, S_MAX));
        send_strain(make_strain(S_ONE, S_ONE, S_ONE, S_MIN, S_MIN, S_MAX));
        send_strain(make_strain(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    endtask

    task automatic check_saturation();
        set_coeffs(C_MAX, C_MAX, C_MAX, C_MAX);
        send_strain(make_strain(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
        send_strain(make_strain(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
        send_strain(make_strain(S_MIN, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN));
        send_strain(make_strain(S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO));
        set_coeffs(C_MIN, C_MIN, C_MIN, C_MIN);
        send_strain(make_strain(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
        send_strain(make_strain(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
        send_strain(make_strain(S_MIN, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN));
        send_strain(make_strain(S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO));
    endtask

    // writes past the last register must leave the coefficients alone
    task automatic check_ignored_addresses();
        set_coeffs(32'sh0002_4000, -32'sh0001_8000, 32'sh0000_C000, -32'sh0003_0000);
        write_reg(REG_BEYOND_LAST, C_MAX);
        write_reg(REG_ADDR_TOP, 32'hFFFF_FFFF);
        repeat (3) send_strain(random_strain(1'b0));
    endtask

    task automatic check_random_phases();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_coeffs(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff());
            steady = (p == 2);
            repeat (PHASE_ITEMS) send_strain(random_strain($urandom_range(0, 9) < 3));
        end
        steady = 1'b0;
    endtask

    initial begin : row_checker
        int unsigned stall;
        row_word_t   got;
        row_word_t   want;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(negedge aclk);
            while (!m_tvalid) @(negedge aclk);
            got.row    = m_tuser;
            got.energy = m_tdata[0 +: OUT_W];
            got.grad   = m_tdata[OUT_W +: OUT_W];
            for (int c = 0; c < 6; c++) got.hess[c] = m_tdata[OUT_W * (c + 2) +: OUT_W];
            got.last   = m_tlast;
            @(posedge aclk);
            if (rows_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("row word %0d arrived with nothing pending", got.row);
            end else begin
                want = rows_due.pop_front();
                compare_field("row_index", OUT_W'(want.row), OUT_W'(got.row));
                compare_field("energy", want.energy, got.energy);
                compare_field("gradient_entry", want.grad, got.grad);
                for (int c = 0; c < 6; c++)
                    compare_field($sformatf("hess_col%0d", c), want.hess[c], got.hess[c]);
                compare_field("last_row", OUT_W'(want.last), OUT_W'(got.last));
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_reset_coefficients();
        check_directed_strains();
        check_saturation();
        check_ignored_addresses();
        check_random_phases();
        wait_drained();
        if (fail_count == 0 && rows_due.size() == 0) begin
            $display("[shell_strain_energy_derivatives_top] OK");
        end else begin
            $display("[shell_strain_energy_derivatives_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
